/* src/rgbled_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rgbled_pkg;

    // Field widths.
    localparam int PCT_W           = 7;
    localparam int MODE_W          = 3;
    localparam int OP_W            = 2;
    localparam int DATA_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int REG_IDX_W       = PADDR_W - 2;
    localparam int DEF_COUNT_WIDTH = 32;

    // Register reset values.
    localparam logic [DATA_W-1:0] PERIOD_RESET = 32'd10000;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Operation codes of an input word.
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_SET_COLOR = 2'd1,
        OP_SET_MODE  = 2'd2
    } op_t;

    // Effect modes; the two remaining codes are idle modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_STATIC  = 3'd0,
        MODE_SMOOTH  = 3'd1,
        MODE_DISCO   = 3'd2,
        MODE_BREATH  = 3'd3,
        MODE_RAINBOW = 3'd4,
        MODE_PULSE   = 3'd5
    } mode_t;

    // Register map, by word index.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PERIOD = 1'd0
    } reg_idx_t;

    typedef logic [PCT_W-1:0] pct_t;

    typedef struct packed {
        pct_t red;
        pct_t green;
        pct_t blue;
    } rgb_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        pct_t              red_in;
        pct_t              green_in;
        pct_t              blue_in;
        logic [MODE_W-1:0] mode_in;
    } item_t;

    typedef struct packed {
        rgb_t              color;
        logic [MODE_W-1:0] mode;
    } result_t;

endpackage

`default_nettype wire

/* src/rgbled_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one command or tick per word.
interface rgbled_in_if;
    import rgbled_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [PCT_W-1:0]  red_in;
    logic [PCT_W-1:0]  green_in;
    logic [PCT_W-1:0]  blue_in;
    logic [MODE_W-1:0] mode_in;

    modport source (
        output valid, operation, red_in, green_in, blue_in, mode_in,
        input  ready
    );

    modport sink (
        input  valid, operation, red_in, green_in, blue_in, mode_in,
        output ready
    );
endinterface

// Output channel: current colors, compare values and mode.
interface rgbled_out_if;
    import rgbled_pkg::*;

    logic              valid;
    logic              ready;
    logic [PCT_W-1:0]  red_pct;
    logic [PCT_W-1:0]  green_pct;
    logic [PCT_W-1:0]  blue_pct;
    logic [DATA_W-1:0] red_compare;
    logic [DATA_W-1:0] green_compare;
    logic [DATA_W-1:0] blue_compare;
    logic [MODE_W-1:0] mode_out;

    modport source (
        output valid, red_pct, green_pct, blue_pct,
               red_compare, green_compare, blue_compare, mode_out,
        input  ready
    );

    modport sink (
        input  valid, red_pct, green_pct, blue_pct,
               red_compare, green_compare, blue_compare, mode_out,
        output ready
    );
endinterface

`default_nettype wire

/* src/rgb_led_effect_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// RGB LED effect engine. Each input word is a tick, a set-color command or a
// set-mode command, and each one yields exactly one output word with the
// current red, green and blue percentages, the PWM compare values
// (period / 100) * percent and the active mode. The block takes one word per
// clock cycle: all effect arithmetic fits between the state registers and a
// two-word result queue, so a result is written into the queue as its word is
// accepted, and input ready only drops when two results wait unread. The PWM
// period is written over the APB port at address 0; the user must write it only
// while no word is in flight, as the block does not enforce it. Period / 100 is
// formed at the write and the compare values are one multiply on the queue head.
module rgb_led_effect_generator #(
    parameter int COUNT_WIDTH = rgbled_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rgbled_pkg::PADDR_W-1:0] paddr,
    input  logic [rgbled_pkg::DATA_W-1:0]  pwdata,
    output logic [rgbled_pkg::DATA_W-1:0]  prdata,
    output logic                           pready,
    rgbled_in_if.sink                      in_ch,
    rgbled_out_if.source                   out_ch
);
    import rgbled_pkg::*;

    localparam logic [DATA_W-1:0] STEP_RESET = DATA_W'(PERIOD_RESET / 100);

    logic [DATA_W-1:0]    period_reg, period_next;
    logic [DATA_W-1:0]    step_reg, step_next;
    logic [2*DATA_W-1:0]  step_prod;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    logic                 fire;
    logic                 full;
    logic                 head_valid;
    item_t                in_item;
    result_t              eff_result;
    result_t              head;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Period / 100 by the reciprocal 0x51EB851F with a shift of 37.
    assign step_prod = 64'(pwdata) * 64'h0000_0000_51EB_851F;

    always_comb
    begin
        period_next = period_reg;
        step_next   = step_reg;
        prdata      = '0;
        unique case (reg_idx)
            REG_PERIOD:
            begin
                prdata = period_reg;
                if (cfg_write)
                begin
                    period_next = pwdata;
                    step_next   = DATA_W'(step_prod[2*DATA_W-1:37]);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            step_reg   <= STEP_RESET;
        end
        else
        begin
            period_reg <= period_next;
            step_reg   <= step_next;
        end
    end

    // Input word.
    assign in_ch.ready       = !full;
    assign fire              = in_ch.valid && !full;
    assign in_item.operation = in_ch.operation;
    assign in_item.red_in    = in_ch.red_in;
    assign in_item.green_in  = in_ch.green_in;
    assign in_item.blue_in   = in_ch.blue_in;
    assign in_item.mode_in   = in_ch.mode_in;

    rgbled_effect #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_effect (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item),
        .result (eff_result)
    );

    rgbled_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_data  (eff_result),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (out_ch.ready)
    );

    // Output word; compare values come from the queue head.
    assign out_ch.valid         = head_valid;
    assign out_ch.red_pct       = head.color.red;
    assign out_ch.green_pct     = head.color.green;
    assign out_ch.blue_pct      = head.color.blue;
    assign out_ch.mode_out      = head.mode;
    assign out_ch.red_compare   = DATA_W'(step_reg * DATA_W'(head.color.red));
    assign out_ch.green_compare = DATA_W'(step_reg * DATA_W'(head.color.green));
    assign out_ch.blue_compare  = DATA_W'(step_reg * DATA_W'(head.color.blue));

endmodule

`default_nettype wire

/* src/rgbled_effect.sv */
`timescale 1ns / 1ps
`default_nettype none

module rgbled_effect #(
    parameter int COUNT_WIDTH = rgbled_pkg::DEF_COUNT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  rgbled_pkg::item_t   item,
    output rgbled_pkg::result_t result
);
    import rgbled_pkg::*;

    // Moduli of the tick count that the effects need, the last disco index and the breath step.
    localparam logic [7:0] R255_LAST = 8'd254;
    localparam logic [8:0] R360_LAST = 9'd359;
    localparam logic [3:0] R12_LAST  = 4'd11;
    localparam logic [2:0] DISCO_LAST = 3'd6;
    localparam logic [PCT_W-1:0] BREATH_STEP = 7'd5;

    // Saturate a raw percent at 100.
    function automatic pct_t sat_pct(input pct_t v);
        sat_pct = (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    // Floor of x / 17 for x below 2048.
    function automatic pct_t div17(input logic [10:0] x);
        logic [18:0] p;
        p = 19'(x) * 19'd241;
        div17 = p[18:12];
    endfunction

    // Floor of x / 3 for x below 384.
    function automatic pct_t div3(input logic [8:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd683;
        div3 = p[17:11];
    endfunction

    // Floor of x / 100 for x up to 10000.
    function automatic pct_t div100(input logic [13:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'd5243;
        div100 = p[25:19];
    endfunction

    // Seven-color palette of the disco effect.
    function automatic rgb_t disco_color(input logic [2:0] idx);
        case (idx)
            3'd0:    disco_color = '{red: PCT_MAX, green: '0,      blue: '0};
            3'd1:    disco_color = '{red: '0,      green: PCT_MAX, blue: '0};
            3'd2:    disco_color = '{red: '0,      green: '0,      blue: PCT_MAX};
            3'd3:    disco_color = '{red: PCT_MAX, green: PCT_MAX, blue: '0};
            3'd4:    disco_color = '{red: PCT_MAX, green: '0,      blue: PCT_MAX};
            3'd5:    disco_color = '{red: '0,      green: PCT_MAX, blue: PCT_MAX};
            default: disco_color = '{red: PCT_MAX, green: PCT_MAX, blue: PCT_MAX};
        endcase
    endfunction

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             r255_reg, r255_next;
    logic [8:0]             r360_reg, r360_next;
    logic [3:0]             r12_reg, r12_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    rgb_t                   color_reg, color_next;
    pct_t                   level_reg, level_next;
    logic                   rising_reg, rising_next;
    rgb_t                   target_reg, target_next;
    logic [2:0]             disco_reg, disco_next;

    logic [COUNT_WIDTH-1:0] c_inc;
    logic                   wrap;
    logic [7:0]             r255_inc;
    logic [8:0]             r360_inc;
    logic [3:0]             r12_inc;
    logic                   r6_zero;

    logic [8:0] sm_v2;
    logic [7:0] sm_v;
    pct_t       sm_d;
    pct_t       sm_q;
    rgb_t       smooth_color;

    logic [5:0] rb_d;
    pct_t       rb_q;
    rgb_t       rainbow_color;

    pct_t       pu_q;
    rgb_t       pulse_color;

    logic [2:0] disco_inc;

    logic [PCT_W:0] lvl_sum;
    pct_t       level_upd;
    logic       rising_upd;
    rgb_t       breath_color;

    // Tick count after the advance, and its residues; all restart on a wrap.
    always_comb
    begin
        c_inc    = count_reg + COUNT_WIDTH'(1);
        wrap     = &count_reg;
        r255_inc = (wrap || r255_reg == R255_LAST) ? '0 : r255_reg + 8'd1;
        r360_inc = (wrap || r360_reg == R360_LAST) ? '0 : r360_reg + 9'd1;
        r12_inc  = (wrap || r12_reg == R12_LAST)   ? '0 : r12_reg + 4'd1;
        r6_zero  = (r12_inc == 4'd0) || (r12_inc == 4'd6);
    end

    // Smooth ramp: v = 2c mod 255 in three thirds of 85.
    always_comb
    begin
        sm_v2 = {r255_inc, 1'b0};
        sm_v  = (sm_v2 >= 9'd255) ? 8'(sm_v2 - 9'd255) : sm_v2[7:0];
        if (sm_v < 8'd85)
            sm_d = sm_v[PCT_W-1:0];
        else if (sm_v < 8'd170)
            sm_d = PCT_W'(sm_v - 8'd85);
        else
            sm_d = PCT_W'(sm_v - 8'd170);
        sm_q = div17(11'(sm_d) * 11'd20);
        if (sm_v < 8'd85)
            smooth_color = '{red: PCT_MAX, green: sm_q, blue: '0};
        else if (sm_v < 8'd170)
            smooth_color = '{red: PCT_MAX - sm_q, green: PCT_MAX, blue: '0};
        else
            smooth_color = '{red: '0, green: PCT_MAX - sm_q, blue: PCT_MAX};
    end

    // Rainbow: hue is c mod 360, six sectors of 60.
    always_comb
    begin
        if (r360_inc < 9'd60)
            rb_d = r360_inc[5:0];
        else if (r360_inc < 9'd120)
            rb_d = 6'(r360_inc - 9'd60);
        else if (r360_inc < 9'd180)
            rb_d = 6'(r360_inc - 9'd120);
        else if (r360_inc < 9'd240)
            rb_d = 6'(r360_inc - 9'd180);
        else if (r360_inc < 9'd300)
            rb_d = 6'(r360_inc - 9'd240);
        else
            rb_d = 6'(r360_inc - 9'd300);
        rb_q = div3(9'(rb_d) * 9'd5);
        if (r360_inc < 9'd60)
            rainbow_color = '{red: PCT_MAX, green: rb_q, blue: '0};
        else if (r360_inc < 9'd120)
            rainbow_color = '{red: PCT_MAX - rb_q, green: PCT_MAX, blue: '0};
        else if (r360_inc < 9'd180)
            rainbow_color = '{red: '0, green: PCT_MAX, blue: rb_q};
        else if (r360_inc < 9'd240)
            rainbow_color = '{red: '0, green: PCT_MAX - rb_q, blue: PCT_MAX};
        else if (r360_inc < 9'd300)
            rainbow_color = '{red: rb_q, green: '0, blue: PCT_MAX};
        else
            rainbow_color = '{red: PCT_MAX, green: '0, blue: PCT_MAX - rb_q};
    end

    // Pulse: the angle 15c mod 180 is 15 times c mod 12, so each sector of 60
    // covers four counts and the ramp moves 25 percent per count.
    always_comb
    begin
        pu_q = PCT_W'(r12_inc[1:0]) * 7'd25;
        case (r12_inc[3:2])
            2'd0:    pulse_color = '{red: '0, green: pu_q >> 1, blue: PCT_MAX};
            2'd1:    pulse_color = '{red: '0, green: (PCT_MAX - pu_q) >> 1,
                                     blue: PCT_MAX};
            default: pulse_color = '{red: '0, green: '0, blue: PCT_MAX - pu_q};
        endcase
    end

    // Disco steps through its palette and wraps after white.
    assign disco_inc = (disco_reg == DISCO_LAST) ? '0 : disco_reg + 3'd1;

    // Breath level moves by five between 0 and 100 and scales the target.
    always_comb
    begin
        lvl_sum    = {1'b0, level_reg} + {1'b0, BREATH_STEP};
        level_upd  = level_reg;
        rising_upd = rising_reg;
        if (rising_reg)
        begin
            if (lvl_sum >= {1'b0, PCT_MAX})
            begin
                level_upd  = PCT_MAX;
                rising_upd = 1'b0;
            end
            else
            begin
                level_upd = lvl_sum[PCT_W-1:0];
            end
        end
        else
        begin
            if (level_reg <= BREATH_STEP)
            begin
                level_upd  = '0;
                rising_upd = 1'b1;
            end
            else
            begin
                level_upd = level_reg - BREATH_STEP;
            end
        end
        breath_color.red   = div100(14'(target_reg.red)   * 14'(level_upd));
        breath_color.green = div100(14'(target_reg.green) * 14'(level_upd));
        breath_color.blue  = div100(14'(target_reg.blue)  * 14'(level_upd));
    end

    // Next state for one accepted word.
    always_comb
    begin
        count_next  = count_reg;
        r255_next   = r255_reg;
        r360_next   = r360_reg;
        r12_next    = r12_reg;
        mode_next   = mode_reg;
        color_next  = color_reg;
        level_next  = level_reg;
        rising_next = rising_reg;
        target_next = target_reg;
        disco_next  = disco_reg;
        if (fire)
        begin
            unique case (item.operation)
                OP_TICK:
                begin
                    count_next = c_inc;
                    r255_next  = r255_inc;
                    r360_next  = r360_inc;
                    r12_next   = r12_inc;
                    case (mode_reg)
                        MODE_SMOOTH:
                        begin
                            color_next = smooth_color;
                        end
                        MODE_DISCO:
                        begin
                            if (r6_zero)
                            begin
                                disco_next = disco_inc;
                                color_next = disco_color(disco_inc);
                            end
                        end
                        MODE_BREATH:
                        begin
                            if (!c_inc[0])
                            begin
                                level_next  = level_upd;
                                rising_next = rising_upd;
                                color_next  = breath_color;
                            end
                        end
                        MODE_RAINBOW:
                        begin
                            color_next = rainbow_color;
                        end
                        MODE_PULSE:
                        begin
                            color_next = pulse_color;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_SET_COLOR:
                begin
                    color_next.red   = sat_pct(item.red_in);
                    color_next.green = sat_pct(item.green_in);
                    color_next.blue  = sat_pct(item.blue_in);
                end
                OP_SET_MODE:
                begin
                    mode_next   = item.mode_in;
                    count_next  = '0;
                    r255_next   = '0;
                    r360_next   = '0;
                    r12_next    = '0;
                    level_next  = '0;
                    rising_next = 1'b1;
                    if (item.mode_in == MODE_BREATH)
                        target_next = color_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The result reports the state after this word.
    assign result.color = color_next;
    assign result.mode  = mode_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            r255_reg   <= '0;
            r360_reg   <= '0;
            r12_reg    <= '0;
            mode_reg   <= MODE_STATIC;
            color_reg  <= '0;
            level_reg  <= '0;
            rising_reg <= 1'b1;
            target_reg <= '0;
            disco_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            r255_reg   <= r255_next;
            r360_reg   <= r360_next;
            r12_reg    <= r12_next;
            mode_reg   <= mode_next;
            color_reg  <= color_next;
            level_reg  <= level_next;
            rising_reg <= rising_next;
            target_reg <= target_next;
            disco_reg  <= disco_next;
        end
    end

    // A mode change restarts the count, its residues and the breath state.
    a_mode_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_SET_MODE |=>
            count_reg == '0 && r360_reg == '0 && level_reg == '0 && rising_reg)
        else $error("mode change did not restart effect state");

    // The residues restart together, so a multiple of 360 is one of 12.
    a_residue_align: assert property (@(posedge clk) disable iff (!rst_n)
        r360_reg == '0 |-> r12_reg == '0)
        else $error("count residues out of step");

    // Breath only falls from a nonzero level.
    a_breath_fall: assert property (@(posedge clk) disable iff (!rst_n)
        !rising_reg |-> level_reg != '0)
        else $error("breath falling at level zero");

endmodule

`default_nettype wire

/* src/rgbled_resq.sv */
`timescale 1ns / 1ps
`default_nettype none

module rgbled_resq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rgbled_pkg::result_t push_data,
    output logic                full,
    output logic                head_valid,
    output rgbled_pkg::result_t head,
    input  logic                pop
);
    import rgbled_pkg::*;

    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    logic       pop_ok;

    assign pop_ok     = pop && (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = head_reg;

    // Two-word queue: the head is always the oldest word.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg + 2'(push) - 2'(pop_ok);
        if (pop_ok)
        begin
            if (count_reg == 2'd2)
            begin
                head_next = tail_reg;
                if (push)
                    tail_next = push_data;
            end
            else if (push)
            begin
                head_next = push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                head_next = push_data;
            else
                tail_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("word pushed into a full result queue");

    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && !pop |=> $stable(head_reg))
        else $error("waiting result word changed");

    a_tail_advances: assert property (@(posedge clk) disable iff (!rst_n)
        pop && full |=> head_reg == $past(tail_reg))
        else $error("second word did not move to the head");

endmodule

`default_nettype wire
